// ----- rtl/block_chained_murmur3_hash_unit_defines.svh -----
// Assertion macros for the chained murmur3 hash unit.
// Used by the port checker; expects clk and rst_n in the using scope.
`ifndef BLOCK_CHAINED_MURMUR3_HASH_UNIT_DEFINES_SVH
`define BLOCK_CHAINED_MURMUR3_HASH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define BCMH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define BCMH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bcmh_pkg.sv -----
// Shared constants and types for the chained murmur3 hash unit.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package bcmh_pkg;

  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned CNT_W       = $clog2(BLOCK_BYTES + 4);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned BCNT_W      = 3;

  localparam logic [WORD_W-1:0] MIX_C1  = 32'hcc9e2d51;
  localparam logic [WORD_W-1:0] MIX_C2  = 32'h1b873593;
  localparam logic [WORD_W-1:0] MIX_ADD = 32'he6546b64;
  localparam logic [WORD_W-1:0] FIN_M1  = 32'h85ebca6b;
  localparam logic [WORD_W-1:0] FIN_M2  = 32'hc2b2ae35;

  localparam logic [BCNT_W-1:0] FULL_WORD_BYTES = 3'd4;

  typedef struct packed {
    logic accept;
    logic load_seed;
    logic mul1;
    logic mul2;
    logic upd;
    logic fin1;
    logic fin2;
    logic fin3;
    logic emit;
  } bcmh_cmd_t;

  typedef struct packed {
    logic no_bytes;
    logic close_next;
    logic last;
  } bcmh_status_t;

endpackage

`default_nettype wire

// ----- rtl/bcmh_if.sv -----
// Valid/ready channel interfaces for the chained murmur3 hash unit.
// Depends on nothing; used by the top level.
`default_nettype none

interface bcmh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last_word;
  modport source (output valid, input ready, output data_word, output byte_count,
                  output last_word);
  modport sink (input valid, output ready, input data_word, input byte_count,
                input last_word);
endinterface

interface bcmh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest;
  modport source (output valid, input ready, output digest);
  modport sink (input valid, output ready, input digest);
endinterface

interface bcmh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, input ready, output data);
  modport sink (input valid, output ready, input data);
endinterface

`default_nettype wire

// ----- rtl/bcmh_datapath.sv -----
// Datapath: seed register, key mix, hash update, finalizer and result register.
// Depends on bcmh_pkg; driven by bcmh_ctrl.
`default_nettype none

module bcmh_datapath (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire [31:0]               cfg_data,
  input  wire [31:0]               data_word,
  input  wire [2:0]                byte_count,
  input  wire                      last_word,
  input  bcmh_pkg::bcmh_cmd_t      cmd,
  output bcmh_pkg::bcmh_status_t   status,
  output logic [31:0]              digest
);
  import bcmh_pkg::*;

  logic [WORD_W-1:0] start_seed_r;
  logic [WORD_W-1:0] hash_r, hash_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BCNT_W-1:0] nbytes_r, nbytes_nxt;
  logic              last_r, last_nxt;
  logic [WORD_W-1:0] out_hash_r;

  logic [BCNT_W-1:0] n_clamp;
  logic [WORD_W-1:0] tail_mask;
  logic [CNT_W-1:0]  cnt_upd;
  logic [WORD_W-1:0] key_rot;
  logic [WORD_W-1:0] body_mix;
  logic [WORD_W-1:0] fin_a;
  logic [WORD_W-1:0] fin_b;

  always_comb begin
    n_clamp = (byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : byte_count;
    case (n_clamp)
      3'd1:    tail_mask = 32'h0000_00ff;
      3'd2:    tail_mask = 32'h0000_ffff;
      3'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'hffff_ffff;
    endcase
  end

  assign cnt_upd  = cnt_r + CNT_W'(nbytes_r);
  assign key_rot  = {key_r[16:0], key_r[31:17]};
  assign body_mix = {(hash_r[18:0] ^ key_r[18:0]), (hash_r[31:19] ^ key_r[31:19])};
  assign fin_a    = hash_r ^ WORD_W'(cnt_r);
  assign fin_b    = hash_r ^ (hash_r >> 13);

  assign status.no_bytes   = (nbytes_r == '0);
  assign status.close_next = (cnt_upd >= CNT_W'(BLOCK_BYTES)) ||
                             (last_r && (cnt_upd != '0));
  assign status.last       = last_r;

  always_comb begin
    hash_nxt   = hash_r;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    nbytes_nxt = nbytes_r;
    last_nxt   = last_r;
    if (cmd.accept) begin
      key_nxt    = data_word & tail_mask;
      nbytes_nxt = n_clamp;
      last_nxt   = last_word || (n_clamp != FULL_WORD_BYTES);
      if (cmd.load_seed) begin
        hash_nxt = start_seed_r;
        cnt_nxt  = '0;
      end
    end
    if (cmd.mul1) key_nxt = key_r * MIX_C1;
    if (cmd.mul2) key_nxt = key_rot * MIX_C2;
    if (cmd.upd) begin
      cnt_nxt = cnt_upd;
      if (nbytes_r == FULL_WORD_BYTES) begin
        hash_nxt = (body_mix << 2) + body_mix + MIX_ADD;
      end else if (nbytes_r != '0) begin
        hash_nxt = hash_r ^ key_r;
      end
    end
    if (cmd.fin1) begin
      hash_nxt = (fin_a ^ (fin_a >> 16)) * FIN_M1;
      cnt_nxt  = '0;
    end
    if (cmd.fin2) hash_nxt = fin_b * FIN_M2;
    if (cmd.fin3) hash_nxt = hash_r ^ (hash_r >> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_seed_r <= '0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) start_seed_r <= cfg_data;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r   <= hash_nxt;
    key_r    <= key_nxt;
    nbytes_r <= nbytes_nxt;
    last_r   <= last_nxt;
    if (cmd.emit) out_hash_r <= hash_r;
  end

  assign digest = out_hash_r;

endmodule

`default_nettype wire

// ----- rtl/bcmh_ctrl.sv -----
// Controller: sequences key mix, update, block finalize and result hand-off.
// Depends on bcmh_pkg; commands bcmh_datapath.
`default_nettype none

module bcmh_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  input  bcmh_pkg::bcmh_status_t  status,
  output bcmh_pkg::bcmh_cmd_t     cmd
);
  import bcmh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_UPD,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_file_r, in_file_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_file_nxt   = in_file_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept    = 1'b1;
          cmd.load_seed = !in_file_r;
          in_file_nxt   = 1'b1;
          state_nxt     = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (status.close_next) state_nxt = ST_FIN1;
        else if (status.last)  state_nxt = ST_EMIT;
        else                   state_nxt = ST_IDLE;
      end
      ST_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = ST_FIN3;
      end
      ST_FIN3: begin
        cmd.fin3  = 1'b1;
        state_nxt = status.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          in_file_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // skip the key mix when the word carries no bytes
    if (state_r == ST_MUL1 && status.no_bytes) begin
      cmd.mul1  = 1'b0;
      state_nxt = ST_UPD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_file_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_file_r   <= in_file_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/block_chained_murmur3_hash_unit.sv -----
// Chained murmur3 x86_32 file hash: one word per item, one hash per file.
// A full word passes states MUL1, MUL2, UPD before the next transfer, and
// FIN1, FIN2, FIN3 too when it closes a block; a zero-byte word skips the key
// mix. A last word loads the result register in EMIT, waiting while an earlier
// result is held. No new word is taken until the key-mix multiplier steps and
// serial hash update are through. Reset clears control state, count and seed.
`default_nettype none

module block_chained_murmur3_hash_unit (
  input  wire         clk,
  input  wire         rst_n,
  bcmh_in_if.sink     in_bus,
  bcmh_out_if.source  out_bus,
  bcmh_cfg_if.sink    cfg_bus
);
  import bcmh_pkg::*;

  bcmh_cmd_t    cmd;
  bcmh_status_t status;

  assign cfg_bus.ready = 1'b1;

  bcmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .status    (status),
    .cmd       (cmd)
  );

  bcmh_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_bus.valid),
    .cfg_data   (cfg_bus.data),
    .data_word  (in_bus.data_word),
    .byte_count (in_bus.byte_count),
    .last_word  (in_bus.last_word),
    .cmd        (cmd),
    .status     (status),
    .digest     (out_bus.digest)
  );

endmodule

`default_nettype wire

// ----- rtl/bcmh_checker.sv -----
// Port-level checker for the chained murmur3 hash unit, bound to the top level.
// Depends on block_chained_murmur3_hash_unit_defines.svh.
`default_nettype none
`include "block_chained_murmur3_hash_unit_defines.svh"

module bcmh_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] digest
);

  `BCMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `BCMH_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(digest), "hash moved")
  `BCMH_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after transfer")
  `BCMH_ASSERT_NEXT(a_no_early_out, in_valid && in_ready, !$rose(out_valid), "early result")

endmodule

bind block_chained_murmur3_hash_unit bcmh_checker u_bcmh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_bus.valid),
  .in_ready  (in_bus.ready),
  .out_valid (out_bus.valid),
  .out_ready (out_bus.ready),
  .digest    (out_bus.digest)
);

`default_nettype wire

// ----- dv/murmur3_file_hash_checker.sv -----
`timescale 1ns / 1ps
// Watches the input, result and seed channels of the chained murmur3 hash unit,
// predicts each file hash and compares it with what the block returns.
// Depends on bcmh_pkg for constants and on bcmh_if for the channel interfaces.

module murmur3_digest_checker (
  input  wire  clk,
  input  wire  rst_n,
  bcmh_in_if   in_mon,
  bcmh_out_if  out_mon,
  bcmh_cfg_if  cfg_mon,
  output int   mismatches,
  output int   pending
);

  logic [31:0] seed_reg;
  logic [31:0] chain_hash;
  int unsigned block_bytes;
  bit          in_file;
  logic [31:0] expected_hashes[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_key(input logic [31:0] k);
    logic [31:0] t;
    t = k * bcmh_pkg::MIX_C1;
    t = rotl(t, 15);
    t = t * bcmh_pkg::MIX_C2;
    return t;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h, input logic [31:0] len);
    logic [31:0] t;
    t = h ^ len;
    t = t ^ (t >> 16);
    t = t * bcmh_pkg::FIN_M1;
    t = t ^ (t >> 13);
    t = t * bcmh_pkg::FIN_M2;
    t = t ^ (t >> 16);
    return t;
  endfunction

  task automatic fold_word(input logic [31:0] w, input logic [2:0] bc, input logic lw);
    int unsigned n;
    bit          done;
    logic [31:0] k;
    logic [31:0] h;
    n    = (bc > bcmh_pkg::FULL_WORD_BYTES) ? 4 : int'(bc);
    done = lw || (n < 4);
    if (!in_file) begin
      chain_hash  = seed_reg;
      block_bytes = 0;
      in_file     = 1'b1;
    end
    if (n == 4) begin
      h           = chain_hash ^ scramble_key(w);
      h           = rotl(h, 13);
      h           = h * 32'd5;
      chain_hash  = h + bcmh_pkg::MIX_ADD;
      block_bytes = block_bytes + 4;
    end else if (n > 0) begin
      k           = w & ((32'h1 << (8 * n)) - 32'h1);
      chain_hash  = chain_hash ^ scramble_key(k);
      block_bytes = block_bytes + n;
    end
    if (block_bytes >= bcmh_pkg::BLOCK_BYTES || (done && block_bytes > 0)) begin
      chain_hash  = avalanche(chain_hash, block_bytes);
      block_bytes = 0;
    end
    if (done) begin
      expected_hashes.push_back(chain_hash);
      chain_hash  = seed_reg;
      block_bytes = 0;
      in_file     = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    logic [31:0] want;
    if (!rst_n) begin
      seed_reg    = '0;
      chain_hash  = '0;
      block_bytes = 0;
      in_file     = 1'b0;
      expected_hashes.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch($sformatf("digest %08h with no file pending", out_mon.digest));
        end else begin
          want = expected_hashes.pop_front();
          if (out_mon.digest !== want) begin
            report_mismatch($sformatf("digest %08h, want %08h", out_mon.digest, want));
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        seed_reg = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) begin
        fold_word(in_mon.data_word, in_mon.byte_count, in_mon.last_word);
      end
    end
    pending <= expected_hashes.size();
  end

endmodule

// ----- dv/tb_block_chained_murmur3_hash_unit.sv -----
`timescale 1ns / 1ps
// Top of the chained murmur3 hash unit testbench: clock, reset, word stimulus,
// seed writes, result back-pressure and verdict. Uses murmur3_digest_checker.

module tb_block_chained_murmur3_hash_unit;

  localparam int READY_ALWAYS = 0;
  localparam int READY_COIN   = 1;
  localparam int READY_MASK   = 2;
  localparam int READY_SPARSE = 3;
  localparam logic [7:0] STALL_MASK = 8'b1011_0010;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  bcmh_in_if  in_bus ();
  bcmh_out_if out_bus ();
  bcmh_cfg_if cfg_bus ();

  int err_count;
  int outstanding;

  block_chained_murmur3_hash_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  murmur3_digest_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .cfg_mon    (cfg_bus),
    .mismatches (err_count),
    .pending    (outstanding)
  );

  int         burst_left  = 0;
  int         items_sent  = 0;
  int         stall_mode  = READY_ALWAYS;
  int         stall_span  = 0;
  logic [2:0] stall_phase = '0;

  initial begin
    #3_000_000;
    $display("tb_block_chained_murmur3_hash_unit: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 3'd1;
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(READY_ALWAYS, READY_SPARSE);
      stall_span <= $urandom_range(8, 96);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      READY_ALWAYS: begin
        out_bus.ready <= 1'b1;
      end
      READY_COIN: begin
        out_bus.ready <= 1'($urandom_range(0, 1));
      end
      READY_MASK: begin
        out_bus.ready <= STALL_MASK[stall_phase];
      end
      default: begin
        out_bus.ready <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] full_count();
    if ($urandom_range(0, 5) == 0) begin
      return 3'($urandom_range(5, 7));
    end
    return bcmh_pkg::FULL_WORD_BYTES;
  endfunction

  task automatic put_word(input logic [31:0] d, input logic [2:0] bc, input logic lw);
    if (burst_left == 0) begin
      if (in_bus.valid) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_word  <= d;
    in_bus.byte_count <= bc;
    in_bus.last_word  <= lw;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_file(input int nfull, input logic [2:0] tail);
    for (int i = 0; i < nfull; i++) begin
      put_word(rand_data(), full_count(), 1'b0);
    end
    put_word(rand_data(), tail, 1'b1);
  endtask

  task automatic random_traffic(input int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(0, 6) == 0) begin
        put_word(rand_data(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end else begin
        send_file(int'($urandom_range(0, 6)), 3'($urandom_range(0, 7)));
      end
    end
    // close any file left open by noise
    put_word(rand_data(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    in_bus.valid      = 1'b0;
    in_bus.data_word  = '0;
    in_bus.byte_count = '0;
    in_bus.last_word  = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.data      = '0;
    out_bus.ready     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty file, tails with junk above the count, full last words
    put_word(32'h0000_0000, 3'd0, 1'b1);
    put_word(32'hffff_ffff, 3'd1, 1'b1);
    put_word(32'hffff_ffff, 3'd2, 1'b1);
    put_word(32'hffff_ffff, 3'd3, 1'b1);
    put_word(32'h0000_0000, 3'd4, 1'b1);
    put_word(32'hffff_ffff, 3'd4, 1'b1);
    // counts above four
    put_word(32'hffff_ffff, 3'd5, 1'b1);
    put_word(32'h8000_0001, 3'd6, 1'b0);
    put_word(32'h7fff_fffe, 3'd7, 1'b1);
    // short or empty word without the last flag ends the file
    put_word(32'h1234_5678, 3'd2, 1'b0);
    put_word(32'hffff_ffff, 3'd0, 1'b0);
    // zero-byte final word after data
    put_word(32'hdead_beef, 3'd4, 1'b0);
    put_word(32'hcafe_f00d, 3'd4, 1'b0);
    put_word(32'hffff_ffff, 3'd0, 1'b1);
    // full words followed by tails
    put_word(32'h0102_0304, 3'd4, 1'b0);
    put_word(32'haabb_ccdd, 3'd3, 1'b1);
    put_word(32'h5555_aaaa, 3'd4, 1'b0);
    put_word(32'hffff_ff01, 3'd1, 1'b0);
    random_traffic(12);
    settle();

    write_seed($urandom);
    // first block closes on its last full word, second block seeded by the first
    send_file(int'(bcmh_pkg::BLOCK_BYTES / 4), 3'($urandom_range(1, 7)));
    settle();

    write_seed(32'hffff_ffff);
    random_traffic(8);
    settle();

    write_seed(32'h0000_0000);
    random_traffic(8);
    settle();

    if (err_count == 0) begin
      $display("tb_block_chained_murmur3_hash_unit: done, clean");
    end else begin
      $display("tb_block_chained_murmur3_hash_unit: done, errors");
    end
    $finish;
  end

endmodule
